>>> design/ptrefl_pkg.sv
package ptrefl_pkg;

    // field widths
    localparam int ALPHA_W = 17;
    localparam int VAL_W   = 32;
    localparam int NCOMP   = 3;
    localparam int IN_W    = 216;
    localparam int OUT_W   = 96;

    // gradient normalized to a magnitude in [2^GN_MSB, 2^(GN_MSB+1))
    localparam int GN_MSB  = 14;
    localparam int GN_W    = GN_MSB + 1;
    localparam int SH_W    = 5;

    // datapath widths
    localparam int PGV_W   = GN_W + 1 + VAL_W;
    localparam int PGG_W   = 2 * GN_W;
    localparam int D_W     = PGV_W + 2;
    localparam int N_W     = PGG_W + 2;
    localparam int DMAG_W  = D_W - 2;
    localparam int Q_W     = 32;
    localparam int PROD_W  = GN_W + Q_W;
    localparam int CMAG_SH = GN_MSB - 1;
    localparam int SUM_W   = 36;

    // divider: a few restoring steps per stage
    localparam int DIV_STEP = 4;
    localparam int DIV_STG  = Q_W / DIV_STEP;

    // stage numbers
    localparam int ST_ABS  = 1;
    localparam int ST_MAX  = 2;
    localparam int ST_LZ   = 3;
    localparam int ST_NRM  = 4;
    localparam int ST_MUL  = 5;
    localparam int ST_SUM  = 6;
    localparam int ST_DIV0 = 7;
    localparam int ST_CMUL = ST_DIV0 + DIV_STG + 1;
    localparam int NSTG    = ST_CMUL + 1;

    localparam logic [ALPHA_W-1:0] THR_RESET = ALPHA_W'(32768);
    localparam logic [VAL_W-1:0]   VAL_MAX   = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0]   VAL_MIN   = {1'b1, {(VAL_W-1){1'b0}}};

    typedef logic [NCOMP-1:0][VAL_W-1:0] t_vec3;

    // what travels with every particle down the pipe
    typedef struct packed {
        t_vec3                         vel;
        logic [NCOMP-1:0]              gneg;
        logic [NCOMP-1:0][GN_W-1:0]    gmag;
        logic                          act;
    } t_com;

    // partial state of the divider
    typedef struct packed {
        logic [N_W-1:0] rem;
        logic [Q_W-1:0] lo;
        logic [Q_W-1:0] q;
        logic [N_W-1:0] n;
    } t_div;

endpackage

>>> design/particle_trap_reflection_core.sv
// throughput: one particle per cycle while the output is not stalled; the 32-bit
//   quotient is built by an 8-stage restoring divider at 4 bits per stage, and
//   every stage advances on its own
// reset (i_rst_n, synchronous, active low): all valid bits cleared, threshold
//   back to 0.5 (32768); data registers are not reset
module particle_trap_reflection_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ptrefl_pkg::ALPHA_W-1:0]      i_cfg_wdata,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // cell_alpha[16:0], grad_x, grad_y, grad_z, vel_x, vel_y, vel_z, zero pad
    input  logic [ptrefl_pkg::IN_W-1:0]         i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // new_vel_x[31:0], new_vel_y[63:32], new_vel_z[95:64]
    output logic [ptrefl_pkg::OUT_W-1:0]        o_m_tdata,
    // reflected[0]
    output logic [0:0]                          o_m_tuser
);

    // ------------------------------------------------------------------
    // threshold register
    // ------------------------------------------------------------------
    logic [ptrefl_pkg::ALPHA_W-1:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= ptrefl_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // flow control: each stage moves when it is empty or its successor moves,
    // so bubbles collapse and a stalled output still lets the pipe fill
    // ------------------------------------------------------------------
    logic [ptrefl_pkg::NSTG:1] r_vld;
    logic [ptrefl_pkg::NSTG:1] en;

    always_comb begin
        en[ptrefl_pkg::NSTG] = !r_vld[ptrefl_pkg::NSTG] || i_m_tready;
        for (int k = ptrefl_pkg::NSTG - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_s_tready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_s_tvalid;
            end
            for (int k = 2; k <= ptrefl_pkg::NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // input unpacking
    // ------------------------------------------------------------------
    logic [ptrefl_pkg::ALPHA_W-1:0] in_alpha;
    ptrefl_pkg::t_vec3              in_g;
    ptrefl_pkg::t_vec3              in_v;

    always_comb begin
        in_alpha = i_s_tdata[ptrefl_pkg::ALPHA_W-1:0];
        for (int i = 0; i < ptrefl_pkg::NCOMP; i++) begin
            in_g[i] = i_s_tdata[ptrefl_pkg::ALPHA_W + i*ptrefl_pkg::VAL_W +: ptrefl_pkg::VAL_W];
            in_v[i] = i_s_tdata[ptrefl_pkg::ALPHA_W + (ptrefl_pkg::NCOMP + i)*ptrefl_pkg::VAL_W
                                +: ptrefl_pkg::VAL_W];
        end
    end

    // ------------------------------------------------------------------
    // common payload, stages 1 .. 16
    // act starts as the trap test and is narrowed to "reflect" by stage 7
    // ------------------------------------------------------------------
    ptrefl_pkg::t_com r_com [ptrefl_pkg::NSTG-1:1];
    ptrefl_pkg::t_com n_com [ptrefl_pkg::NSTG-1:1];

    // stage 1..3: gradient magnitudes
    ptrefl_pkg::t_vec3 r_gabs [ptrefl_pkg::ST_ABS:ptrefl_pkg::ST_LZ];
    ptrefl_pkg::t_vec3 n_gabs1;
    // stage 2: largest magnitude
    logic [ptrefl_pkg::VAL_W-1:0] r_m;
    logic [ptrefl_pkg::VAL_W-1:0] n_m;
    // stage 3: normalizing shift
    logic                        r_shr;
    logic [ptrefl_pkg::SH_W-1:0] r_sh;
    logic                        n_shr;
    logic [ptrefl_pkg::SH_W-1:0] n_sh;
    int                          lead;
    // stage 4: normalized magnitudes
    logic [ptrefl_pkg::NCOMP-1:0][ptrefl_pkg::GN_W-1:0] n_gn;
    // stage 5: products
    logic signed [ptrefl_pkg::GN_W:0]    gs    [ptrefl_pkg::NCOMP];
    logic signed [ptrefl_pkg::PGV_W-1:0] r_pgv [ptrefl_pkg::NCOMP];
    logic signed [ptrefl_pkg::PGV_W-1:0] n_pgv [ptrefl_pkg::NCOMP];
    logic [ptrefl_pkg::PGG_W-1:0]        r_pgg [ptrefl_pkg::NCOMP];
    logic [ptrefl_pkg::PGG_W-1:0]        n_pgg [ptrefl_pkg::NCOMP];
    // stage 6: dot products
    logic signed [ptrefl_pkg::D_W-1:0] r_d;
    logic signed [ptrefl_pkg::D_W-1:0] n_d;
    logic [ptrefl_pkg::N_W-1:0]        r_n;
    logic [ptrefl_pkg::N_W-1:0]        n_n;
    // stage 7..15: divider
    ptrefl_pkg::t_div r_div [ptrefl_pkg::ST_CMUL-1:ptrefl_pkg::ST_DIV0];
    ptrefl_pkg::t_div n_div [ptrefl_pkg::ST_CMUL-1:ptrefl_pkg::ST_DIV0];
    logic [ptrefl_pkg::D_W-1:0] dneg;
    // stage 16: correction magnitudes
    logic [ptrefl_pkg::PROD_W-1:0] r_prod [ptrefl_pkg::NCOMP];
    logic [ptrefl_pkg::PROD_W-1:0] n_prod [ptrefl_pkg::NCOMP];
    // stage 17: output register
    ptrefl_pkg::t_vec3 r_ov;
    ptrefl_pkg::t_vec3 n_ov;
    logic              r_orefl;

    // four restoring division steps
    function automatic ptrefl_pkg::t_div div_steps(input ptrefl_pkg::t_div a);
        ptrefl_pkg::t_div          b;
        logic [ptrefl_pkg::N_W:0]  t;
        b = a;
        for (int j = 0; j < ptrefl_pkg::DIV_STEP; j++) begin
            t    = {b.rem, b.lo[ptrefl_pkg::Q_W-1]};
            b.lo = b.lo << 1;
            if (t >= {1'b0, b.n}) begin
                b.rem = ptrefl_pkg::N_W'(t - {1'b0, b.n});
                b.q   = {b.q[ptrefl_pkg::Q_W-2:0], 1'b1};
            end else begin
                b.rem = t[ptrefl_pkg::N_W-1:0];
                b.q   = {b.q[ptrefl_pkg::Q_W-2:0], 1'b0};
            end
        end
        return b;
    endfunction

    always_comb begin
        // stage 1: magnitudes and the threshold compare
        n_com[1].vel  = in_v;
        n_com[1].gmag = '0;
        n_com[1].act  = in_alpha < r_thr;
        for (int i = 0; i < ptrefl_pkg::NCOMP; i++) begin
            n_com[1].gneg[i] = in_g[i][ptrefl_pkg::VAL_W-1];
            n_gabs1[i] = in_g[i][ptrefl_pkg::VAL_W-1] ? (ptrefl_pkg::VAL_W'(0) - in_g[i])
                                                       : in_g[i];
        end

        for (int k = 2; k < ptrefl_pkg::NSTG; k++) begin
            n_com[k] = r_com[k-1];
        end

        // stage 2: largest magnitude, zero gradient drops out here
        n_m = '0;
        for (int i = 0; i < ptrefl_pkg::NCOMP; i++) begin
            if (r_gabs[ptrefl_pkg::ST_ABS][i] > n_m) begin
                n_m = r_gabs[ptrefl_pkg::ST_ABS][i];
            end
        end
        n_com[ptrefl_pkg::ST_MAX].act = r_com[ptrefl_pkg::ST_ABS].act && (n_m != '0);

        // stage 3: position of the leading one picks shift direction and amount
        lead = 0;
        for (int b = 0; b < ptrefl_pkg::VAL_W; b++) begin
            if (r_m[b]) begin
                lead = b;
            end
        end
        n_shr = lead > ptrefl_pkg::GN_MSB;
        n_sh  = n_shr ? ptrefl_pkg::SH_W'(lead - ptrefl_pkg::GN_MSB)
                      : ptrefl_pkg::SH_W'(ptrefl_pkg::GN_MSB - lead);

        // stage 4: normalize; right shift of the magnitude truncates toward zero
        for (int i = 0; i < ptrefl_pkg::NCOMP; i++) begin
            n_gn[i] = r_shr ? ptrefl_pkg::GN_W'(r_gabs[ptrefl_pkg::ST_LZ][i] >> r_sh)
                            : ptrefl_pkg::GN_W'(r_gabs[ptrefl_pkg::ST_LZ][i] << r_sh);
        end
        n_com[ptrefl_pkg::ST_NRM].gmag = n_gn;

        // stage 5: g'.v and g'.g' terms
        for (int i = 0; i < ptrefl_pkg::NCOMP; i++) begin
            gs[i] = r_com[ptrefl_pkg::ST_NRM].gneg[i]
                  ? -$signed({1'b0, r_com[ptrefl_pkg::ST_NRM].gmag[i]})
                  :  $signed({1'b0, r_com[ptrefl_pkg::ST_NRM].gmag[i]});
            n_pgv[i] = ptrefl_pkg::PGV_W'(gs[i])
                     * ptrefl_pkg::PGV_W'($signed(r_com[ptrefl_pkg::ST_NRM].vel[i]));
            n_pgg[i] = ptrefl_pkg::PGG_W'(r_com[ptrefl_pkg::ST_NRM].gmag[i])
                     * ptrefl_pkg::PGG_W'(r_com[ptrefl_pkg::ST_NRM].gmag[i]);
        end

        // stage 6: sums
        n_d = ptrefl_pkg::D_W'(r_pgv[0]) + ptrefl_pkg::D_W'(r_pgv[1])
            + ptrefl_pkg::D_W'(r_pgv[2]);
        n_n = ptrefl_pkg::N_W'(r_pgg[0]) + ptrefl_pkg::N_W'(r_pgg[1])
            + ptrefl_pkg::N_W'(r_pgg[2]);

        // stage 7: reflect only when moving against the gradient;
        // dividend is |d| * 2^14, its high word already below n
        n_com[ptrefl_pkg::ST_DIV0].act = r_com[ptrefl_pkg::ST_SUM].act
                                      && r_d[ptrefl_pkg::D_W-1];
        dneg = ptrefl_pkg::D_W'(0) - r_d;
        n_div[ptrefl_pkg::ST_DIV0].rem =
            ptrefl_pkg::N_W'(dneg[ptrefl_pkg::DMAG_W-1:ptrefl_pkg::Q_W-ptrefl_pkg::GN_MSB]);
        n_div[ptrefl_pkg::ST_DIV0].lo  =
            {dneg[ptrefl_pkg::Q_W-ptrefl_pkg::GN_MSB-1:0], {ptrefl_pkg::GN_MSB{1'b0}}};
        n_div[ptrefl_pkg::ST_DIV0].q   = '0;
        n_div[ptrefl_pkg::ST_DIV0].n   = r_n;

        // stages 8..15: division
        for (int k = ptrefl_pkg::ST_DIV0 + 1; k < ptrefl_pkg::ST_CMUL; k++) begin
            n_div[k] = div_steps(r_div[k-1]);
        end

        // stage 16: |g'| * |s|, sign handled at the end
        for (int i = 0; i < ptrefl_pkg::NCOMP; i++) begin
            n_prod[i] = ptrefl_pkg::PROD_W'(r_com[ptrefl_pkg::ST_CMUL-1].gmag[i])
                      * ptrefl_pkg::PROD_W'(r_div[ptrefl_pkg::ST_CMUL-1].q);
        end
    end

    // stage 17: |c| = |g'| |s| / 2^13; s is negative, so v - c = v + sign(g') |c|
    always_comb begin
        logic signed [ptrefl_pkg::SUM_W-1:0] vext;
        logic signed [ptrefl_pkg::SUM_W-1:0] cext;
        logic signed [ptrefl_pkg::SUM_W-1:0] sum;
        for (int i = 0; i < ptrefl_pkg::NCOMP; i++) begin
            vext = ptrefl_pkg::SUM_W'($signed(r_com[ptrefl_pkg::ST_CMUL].vel[i]));
            cext = $signed(ptrefl_pkg::SUM_W'(r_prod[i] >> ptrefl_pkg::CMAG_SH));
            sum  = r_com[ptrefl_pkg::ST_CMUL].gneg[i] ? (vext - cext) : (vext + cext);
            if (!r_com[ptrefl_pkg::ST_CMUL].act) begin
                n_ov[i] = r_com[ptrefl_pkg::ST_CMUL].vel[i];
            end else if (!sum[ptrefl_pkg::SUM_W-1]
                         && (|sum[ptrefl_pkg::SUM_W-2:ptrefl_pkg::VAL_W-1])) begin
                n_ov[i] = ptrefl_pkg::VAL_MAX;
            end else if (sum[ptrefl_pkg::SUM_W-1]
                         && !(&sum[ptrefl_pkg::SUM_W-2:ptrefl_pkg::VAL_W-1])) begin
                n_ov[i] = ptrefl_pkg::VAL_MIN;
            end else begin
                n_ov[i] = sum[ptrefl_pkg::VAL_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // pipeline registers, each stage on its own enable
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        for (int k = 1; k < ptrefl_pkg::NSTG; k++) begin
            if (en[k]) begin
                r_com[k] <= n_com[k];
            end
        end
        if (en[ptrefl_pkg::ST_ABS]) begin
            r_gabs[ptrefl_pkg::ST_ABS] <= n_gabs1;
        end
        if (en[ptrefl_pkg::ST_MAX]) begin
            r_gabs[ptrefl_pkg::ST_MAX] <= r_gabs[ptrefl_pkg::ST_ABS];
            r_m                        <= n_m;
        end
        if (en[ptrefl_pkg::ST_LZ]) begin
            r_gabs[ptrefl_pkg::ST_LZ] <= r_gabs[ptrefl_pkg::ST_MAX];
            r_shr                     <= n_shr;
            r_sh                      <= n_sh;
        end
        if (en[ptrefl_pkg::ST_MUL]) begin
            r_pgv <= n_pgv;
            r_pgg <= n_pgg;
        end
        if (en[ptrefl_pkg::ST_SUM]) begin
            r_d <= n_d;
            r_n <= n_n;
        end
        for (int k = ptrefl_pkg::ST_DIV0; k < ptrefl_pkg::ST_CMUL; k++) begin
            if (en[k]) begin
                r_div[k] <= n_div[k];
            end
        end
        if (en[ptrefl_pkg::ST_CMUL]) begin
            r_prod <= n_prod;
        end
        if (en[ptrefl_pkg::NSTG]) begin
            r_ov    <= n_ov;
            r_orefl <= r_com[ptrefl_pkg::ST_CMUL].act;
        end
    end

    assign o_m_tvalid   = r_vld[ptrefl_pkg::NSTG];
    assign o_m_tdata    = r_ov;
    assign o_m_tuser[0] = r_orefl;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // an empty output register never holds back the input side
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[ptrefl_pkg::NSTG] |-> o_s_tready)
        else $error("input blocked with empty output stage");

    // reset leaves no result behind
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // partial remainder of a reflecting particle stays below the divisor
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ptrefl_pkg::ST_DIV0] && r_com[ptrefl_pkg::ST_DIV0].act)
        |-> (r_div[ptrefl_pkg::ST_DIV0].rem < r_div[ptrefl_pkg::ST_DIV0].n))
        else $error("dividend high word not below divisor");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ptrefl_pkg::ST_CMUL-1] && r_com[ptrefl_pkg::ST_CMUL-1].act)
        |-> (r_div[ptrefl_pkg::ST_CMUL-1].rem < r_div[ptrefl_pkg::ST_CMUL-1].n))
        else $error("divider remainder out of range");

endmodule
